// ----- sv/terminal_line_discipline_assert.svh -----
// assertion macros for the terminal line discipline
// used by the top level only, no other dependencies
`ifndef TERMINAL_LINE_DISCIPLINE_ASSERT_SVH
`define TERMINAL_LINE_DISCIPLINE_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define TLD_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tld assertion failed");

// next-cycle implication under synchronous active-low reset
`define TLD_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tld assertion failed");

`endif

// ----- sv/tld_pkg.sv -----
// types and constants of the terminal line discipline
// shared by controller, datapath and top level; no dependencies
package tld_pkg;

  localparam logic [1:0] OP_RECV  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] REG_IFLAGS = 3'd0;
  localparam logic [2:0] REG_LFLAGS = 3'd1;
  localparam logic [2:0] REG_INTR   = 3'd2;
  localparam logic [2:0] REG_SUSP   = 3'd3;
  localparam logic [2:0] REG_ERASE  = 3'd4;
  localparam logic [2:0] REG_KILL   = 3'd5;
  localparam logic [2:0] REG_EOF    = 3'd6;

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INTR = 2'd1;
  localparam logic [1:0] SIG_SUSP = 2'd2;

  localparam logic [1:0] DONE_NONE = 2'd0;
  localparam logic [1:0] DONE_NL   = 2'd1;
  localparam logic [1:0] DONE_EOF  = 2'd2;

  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_NL = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_RD_WAIT, ST_EOF_WAIT, ST_FLUSH, ST_OUT
  } tld_state_t;

  typedef enum logic [3:0] {
    CL_NONE, CL_READ, CL_CLEAR, CL_INTR, CL_SUSP, CL_ERASE,
    CL_KILL, CL_NL, CL_EOF, CL_CHAR, CL_RAW
  } tld_class_t;

  typedef struct packed {
    tld_class_t cls;
    logic       ring_nonempty;
    logic       line_full;
    logic       flush_busy;
    logic       flush_pend;
  } tld_stat_t;

  typedef struct packed {
    logic       latch;
    logic       clear;
    logic [1:0] set_sig;
    logic       erase;
    logic       kill;
    logic       echo;
    logic       store;
    logic [1:0] set_done;
    logic       raw_push;
    logic       ring_rd;
    logic       ring_pop;
    logic       line_rd_last;
    logic       eof_check;
    logic       flush_step;
    logic       strobe;
  } tld_cmd_t;

endpackage

// ----- sv/tld_ctrl.sv -----
// sequencing state machine of the terminal line discipline
// depends on tld_pkg for state, class, status and command types
module tld_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tld_pkg::tld_stat_t stat,
  output tld_pkg::tld_cmd_t  cmd,
  output logic              busy
);
  import tld_pkg::*;

  tld_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat.cls)
          CL_READ: state_nxt = stat.ring_nonempty ? ST_RD_WAIT : ST_OUT;
          CL_NL:   state_nxt = ST_FLUSH;
          CL_EOF:  state_nxt = stat.line_full ? ST_EOF_WAIT : ST_FLUSH;
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_RD_WAIT:  state_nxt = ST_OUT;
      ST_EOF_WAIT: state_nxt = ST_FLUSH;
      ST_FLUSH: begin
        if (!stat.flush_busy && !stat.flush_pend) state_nxt = ST_OUT;
      end
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: cmd.latch = start;
      ST_DECODE: begin
        unique case (stat.cls)
          CL_READ:  cmd.ring_rd = stat.ring_nonempty;
          CL_CLEAR: cmd.clear = 1'b1;
          CL_INTR:  cmd.set_sig = SIG_INTR;
          CL_SUSP:  cmd.set_sig = SIG_SUSP;
          CL_ERASE: cmd.erase = 1'b1;
          CL_KILL:  cmd.kill = 1'b1;
          CL_NL: begin
            cmd.echo = 1'b1;
            cmd.store = 1'b1;
            cmd.set_done = DONE_NL;
          end
          CL_EOF: begin
            // eof byte is never written; full line drops an equal last byte
            cmd.echo = 1'b1;
            cmd.set_done = DONE_EOF;
            cmd.line_rd_last = stat.line_full;
          end
          CL_CHAR: begin
            cmd.echo = 1'b1;
            cmd.store = 1'b1;
          end
          CL_RAW: begin
            cmd.echo = 1'b1;
            cmd.raw_push = 1'b1;
          end
          default: cmd = '0;
        endcase
      end
      ST_RD_WAIT:  cmd.ring_pop = 1'b1;
      ST_EOF_WAIT: cmd.eof_check = 1'b1;
      ST_FLUSH:    cmd.flush_step = 1'b1;
      ST_OUT:      cmd.strobe = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule

// ----- sv/tld_dp.sv -----
// datapath of the terminal line discipline: registers, line store, read ring
// depends on tld_pkg; driven by tld_ctrl commands
module tld_dp #(
  parameter int RING_DEPTH = 256,
  parameter int LINE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tld_pkg::tld_cmd_t  cmd,
  output tld_pkg::tld_stat_t stat,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_char_in,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  output logic               out_echo_valid,
  output logic [7:0]         out_echo_byte,
  output logic [7:0]         out_erase_count,
  output logic [1:0]         out_signal_event,
  output logic [1:0]         out_line_done,
  output logic               out_read_valid,
  output logic [7:0]         out_read_byte,
  output logic               out_readable
);
  import tld_pkg::*;

  localparam int RAW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RCW = $clog2(RING_DEPTH + 1);
  localparam int LLW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [2:0] iflags_r;
  logic [3:0] lflags_r;
  logic [7:0] intr_r, susp_r, erase_ch_r, kill_r, eof_r;

  logic [7:0] ring_mem [RING_DEPTH];
  logic [7:0] line_mem [LINE_DEPTH];
  logic [7:0] ring_q, line_q;

  logic [RAW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [RCW-1:0] count_r, count_nxt;
  logic [LLW-1:0] len_r, len_nxt, idx_r, idx_nxt;
  logic           pend_r, pend_nxt;

  logic [1:0] op_r, op_nxt;
  logic [7:0] c_r, c_nxt;
  logic       ign_r, ign_nxt;

  logic       ev_r, ev_nxt;
  logic [7:0] eb_r, eb_nxt, ec_r, ec_nxt, rb_r, rb_nxt;
  logic [1:0] sig_r, sig_nxt, done_r, done_nxt;
  logic       rv_r, rv_nxt;

  logic           push_en, line_full, flush_busy, line_rd;
  logic [7:0]     push_data, c_in;
  logic           ign_in;
  logic [RAW-1:0] head_inc, tail_inc;
  logic [LLW-1:0] line_addr;
  logic [12:0]    len_wide;
  logic [7:0]     len_sat;
  tld_class_t     cls;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iflags_r   <= 3'd1;
      lflags_r   <= 4'd15;
      intr_r     <= 8'd3;
      susp_r     <= 8'd26;
      erase_ch_r <= 8'd127;
      kill_r     <= 8'd21;
      eof_r      <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IFLAGS: iflags_r   <= cfg_wdata[2:0];
        REG_LFLAGS: lflags_r   <= cfg_wdata[3:0];
        REG_INTR:   intr_r     <= cfg_wdata;
        REG_SUSP:   susp_r     <= cfg_wdata;
        REG_ERASE:  erase_ch_r <= cfg_wdata;
        REG_KILL:   kill_r     <= cfg_wdata;
        REG_EOF:    eof_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // cr/nl translation of the incoming byte
  always_comb begin
    c_in = in_char_in;
    ign_in = 1'b0;
    if (iflags_r[0] && in_char_in == CH_CR) c_in = CH_NL;
    else if (iflags_r[1] && in_char_in == CH_NL) c_in = CH_CR;
    else if (iflags_r[2] && in_char_in == CH_CR) ign_in = 1'b1;
  end

  // item class, checks in priority order
  always_comb begin
    cls = CL_NONE;
    case (op_r)
      OP_READ:  cls = CL_READ;
      OP_CLEAR: cls = CL_CLEAR;
      OP_RECV: begin
        if (ign_r) cls = CL_NONE;
        else if (lflags_r[0] && c_r != 8'd0 && c_r == intr_r) cls = CL_INTR;
        else if (lflags_r[0] && c_r != 8'd0 && c_r == susp_r) cls = CL_SUSP;
        else if (!lflags_r[1]) cls = CL_RAW;
        else if ((c_r != 8'd0 && c_r == erase_ch_r) || c_r == CH_BS) cls = CL_ERASE;
        else if (c_r != 8'd0 && c_r == kill_r) cls = CL_KILL;
        else if (c_r == CH_NL) cls = CL_NL;
        else if (c_r != 8'd0 && c_r == eof_r) cls = CL_EOF;
        else cls = CL_CHAR;
      end
      default: cls = CL_NONE;
    endcase
  end

  assign line_full  = (len_r == LLW'(LINE_DEPTH - 1));
  assign flush_busy = (idx_r < len_r);
  assign head_inc   = (head_r == RAW'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc   = (tail_r == RAW'(RING_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign push_en    = cmd.raw_push | (cmd.flush_step & pend_r);
  assign push_data  = cmd.raw_push ? c_r : line_q;
  assign line_rd    = cmd.line_rd_last | (cmd.flush_step & flush_busy);
  assign line_addr  = cmd.line_rd_last ? len_r - 1'b1 : idx_r;
  assign len_wide   = 13'(len_r);
  assign len_sat    = (len_wide > 13'd255) ? 8'hff : len_wide[7:0];

  assign stat.cls           = cls;
  assign stat.ring_nonempty = (count_r != '0);
  assign stat.line_full     = line_full;
  assign stat.flush_busy    = flush_busy;
  assign stat.flush_pend    = pend_r;

  always_comb begin
    op_nxt = op_r; c_nxt = c_r; ign_nxt = ign_r;
    head_nxt = head_r; tail_nxt = tail_r; count_nxt = count_r;
    len_nxt = len_r; idx_nxt = idx_r; pend_nxt = pend_r;
    ev_nxt = ev_r; eb_nxt = eb_r; ec_nxt = ec_r; sig_nxt = sig_r;
    done_nxt = done_r; rv_nxt = rv_r; rb_nxt = rb_r;
    if (cmd.latch) begin
      op_nxt = in_op; c_nxt = c_in; ign_nxt = ign_in;
      idx_nxt = '0; pend_nxt = 1'b0;
      ev_nxt = 1'b0; eb_nxt = '0; ec_nxt = '0; sig_nxt = SIG_NONE;
      done_nxt = DONE_NONE; rv_nxt = 1'b0; rb_nxt = '0;
    end
    if (cmd.clear) begin
      head_nxt = '0; tail_nxt = '0; count_nxt = '0; len_nxt = '0;
    end
    if (cmd.set_sig != SIG_NONE) sig_nxt = cmd.set_sig;
    if (cmd.set_done != DONE_NONE) done_nxt = cmd.set_done;
    if (cmd.erase && len_r != '0) begin
      len_nxt = len_r - 1'b1;
      if (lflags_r[3]) ec_nxt = 8'd1;
    end
    if (cmd.kill) begin
      if (lflags_r[3]) ec_nxt = len_sat;
      len_nxt = '0;
    end
    if (cmd.echo && lflags_r[2]) begin
      ev_nxt = 1'b1; eb_nxt = c_r;
    end
    if (cmd.store && !line_full) len_nxt = len_r + 1'b1;
    if (cmd.eof_check && line_q == c_r) len_nxt = len_r - 1'b1;
    if (push_en) begin
      head_nxt = head_inc;
      if (count_r == RCW'(RING_DEPTH)) tail_nxt = tail_inc;
      else count_nxt = count_r + 1'b1;
    end
    if (cmd.ring_pop) begin
      rv_nxt = 1'b1; rb_nxt = ring_q;
      tail_nxt = tail_inc; count_nxt = count_r - 1'b1;
    end
    if (cmd.flush_step) begin
      if (flush_busy) begin
        idx_nxt = idx_r + 1'b1; pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
        if (!pend_r) len_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; tail_r <= '0; count_r <= '0; len_r <= '0;
    end else begin
      head_r <= head_nxt; tail_r <= tail_nxt;
      count_r <= count_nxt; len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; c_r <= c_nxt; ign_r <= ign_nxt;
    idx_r <= idx_nxt; pend_r <= pend_nxt;
    ev_r <= ev_nxt; eb_r <= eb_nxt; ec_r <= ec_nxt; sig_r <= sig_nxt;
    done_r <= done_nxt; rv_r <= rv_nxt; rb_r <= rb_nxt;
  end

  always_ff @(posedge clk) begin
    if (push_en) ring_mem[head_r] <= push_data;
    if (cmd.ring_rd) ring_q <= ring_mem[tail_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.store && !line_full) line_mem[len_r] <= c_r;
    if (line_rd) line_q <= line_mem[line_addr];
  end

  assign out_echo_valid   = ev_r;
  assign out_echo_byte    = eb_r;
  assign out_erase_count  = ec_r;
  assign out_signal_event = sig_r;
  assign out_line_done    = done_r;
  assign out_read_valid   = rv_r;
  assign out_read_byte    = rb_r;
  assign out_readable     = (count_r != '0);

endmodule

// ----- sv/terminal_line_discipline.sv -----
// top level of the terminal line discipline
// depends on tld_pkg, tld_ctrl, tld_dp and terminal_line_discipline_assert.svh
//
// An item is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result appears for exactly one cycle
// with out_strobe high and cannot be held off, so the receiver must take it
// then. A plain item (byte, read of an empty ring, clear, signal, erase,
// kill) passes through ST_DECODE and then ST_OUT, which shows the strobe;
// a read that returns a byte passes ST_RD_WAIT between the two. Busy stays
// high through the strobe cycle and falls on the return to ST_IDLE, so a
// new item is taken only after the previous result has been shown. A
// newline or EOF flush copies the pending line into the read ring one byte
// a cycle through the single read port of the line store, in ST_FLUSH
// between ST_DECODE and ST_OUT (after ST_EOF_WAIT when the line store was
// full at EOF). Configuration writes are taken at once and must only be
// made while busy is low.
module terminal_line_discipline #(
  parameter int RING_DEPTH = 256,
  parameter int LINE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_op,
  input  logic [7:0] in_char_in,
  output logic       out_strobe,
  output logic       out_echo_valid,
  output logic [7:0] out_echo_byte,
  output logic [7:0] out_erase_count,
  output logic [1:0] out_signal_event,
  output logic [1:0] out_line_done,
  output logic       out_read_valid,
  output logic [7:0] out_read_byte,
  output logic       out_readable,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import tld_pkg::*;

  // command and status between sequencer and datapath
  tld_cmd_t  cmd;
  tld_stat_t stat;

  tld_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // line store, read ring and result registers
  tld_dp #(
    .RING_DEPTH (RING_DEPTH),
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_op),
    .in_char_in       (in_char_in),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_echo_valid   (out_echo_valid),
    .out_echo_byte    (out_echo_byte),
    .out_erase_count  (out_erase_count),
    .out_signal_event (out_signal_event),
    .out_line_done    (out_line_done),
    .out_read_valid   (out_read_valid),
    .out_read_byte    (out_read_byte),
    .out_readable     (out_readable)
  );

  // result strobe comes from the sequencer's final state
  assign out_strobe = cmd.strobe;

`include "terminal_line_discipline_assert.svh"

  // a result is only ever shown while the item is still held
  `TLD_ASSERT_NOW(a_strobe_busy, clk, rst_n, out_strobe, busy)
  // an accepted item keeps the block busy
  `TLD_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // the block frees up right after its single result
  `TLD_ASSERT_NEXT(a_strobe_free, clk, rst_n, out_strobe, !busy && !out_strobe)

endmodule
